@@ sv/dwcpid_pkg.sv @@
// shared types and constants for the two-wheel cruise speed controller
// no dependencies; imported by every module of the block

package dwcpid_pkg;

	localparam int POS_BITS_DEF = 32;
	localparam int CFG_IDX_W    = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_MS      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D       = 3'd5;

	// distance per tick: |speed*tick| * 32 / 125, split as 125*a + b
	localparam logic [31:0] RECIP_125  = 32'd2199023256;
	localparam logic [6:0]  DIV_125    = 7'd125;
	localparam logic [12:0] RECIP_FRAC = 13'd4195;
	localparam logic [2:0]  DIST_LAT   = 3'd5;

	typedef struct packed {
		logic signed [15:0] p;
		logic signed [15:0] i;
		logic signed [15:0] d;
	} gains_t;

	typedef struct packed {
		logic adv;
		logic load;
		logic upd;
	} lane_ctl_t;

endpackage

@@ sv/dwcpid_dist.sv @@
// distance-per-tick pipeline: target speed times tick length * 256 / 1000
// depends on dwcpid_pkg; used by dual_wheel_cruise_pid_top

module dwcpid_dist (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr,
	input  logic signed [15:0] target_speed,
	input  logic [15:0]        tick_ms,
	output logic signed [31:0] tick_dist,
	output logic               dist_ok
);
	import dwcpid_pkg::*;

	logic signed [16:0] tick_sx;
	logic signed [32:0] prod_s1;
	logic [32:0]        abs_v;
	logic               neg_s2, neg_s3, neg_s4;
	logic [30:0]        mag_s2, mag_s3;
	logic [62:0]        quo_full;
	logic [24:0]        quo_s3, quo_s4;
	logic [30:0]        quo_x125;
	logic [30:0]        rem_full;
	logic [6:0]         rem_s4;
	logic [24:0]        frac_full;
	logic [29:0]        qmag;
	logic signed [31:0] dist_mag;
	logic signed [31:0] dist_q;
	logic [2:0]         wait_q;

	assign tick_sx   = signed'({1'b0, tick_ms});
	assign abs_v     = prod_s1[32] ? unsigned'(-prod_s1) : unsigned'(prod_s1);
	assign quo_full  = 63'(mag_s2) * 63'(RECIP_125);
	assign quo_x125  = 31'(quo_s3) * 31'(DIV_125);
	assign rem_full  = mag_s3 - quo_x125;
	assign frac_full = 25'({rem_s4, 5'b00000}) * 25'(RECIP_FRAC);
	assign qmag      = {quo_s4, 5'b00000} + 30'(frac_full[23:19]);
	assign dist_mag  = signed'({2'b00, qmag});

	always_ff @(posedge clk) begin
		prod_s1 <= 33'(target_speed) * 33'(tick_sx);
		neg_s2  <= prod_s1[32];
		mag_s2  <= abs_v[30:0];
		neg_s3  <= neg_s2;
		mag_s3  <= mag_s2;
		quo_s3  <= quo_full[62:38];
		neg_s4  <= neg_s3;
		quo_s4  <= quo_s3;
		rem_s4  <= rem_full[6:0];
		dist_q  <= neg_s4 ? -dist_mag : dist_mag;
	end

	// hold off items until a new setting has run through the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_q <= DIST_LAT;
		end else if (cfg_wr) begin
			wait_q <= DIST_LAT;
		end else if (wait_q != 3'd0) begin
			wait_q <= wait_q - 3'd1;
		end
	end

	assign tick_dist = dist_q;
	assign dist_ok   = (wait_q == 3'd0);

endmodule

@@ sv/dwcpid_lane.sv @@
// one wheel lane: position state, error terms, gain products, throttle accumulate
// depends on dwcpid_pkg; two copies run in dual_wheel_cruise_pid_top

module dwcpid_lane #(
	parameter int PositionBits = dwcpid_pkg::POS_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dwcpid_pkg::lane_ctl_t ctl,
	input  dwcpid_pkg::gains_t    gains,
	input  logic signed [31:0]    tick_dist,
	input  logic signed [31:0]    position,
	output logic signed [31:0]    throttle
);
	import dwcpid_pkg::*;

	localparam logic signed [63:0] SatHi = 64'sd2147483647;
	localparam logic signed [63:0] SatLo = -64'sd2147483648;

	logic signed [PositionBits-1:0] pos_w, dist_w, ideal_base;
	logic signed [PositionBits-1:0] prev_pos_q, ideal_q;
	logic signed [PositionBits-1:0] delta_s1, perr_s1;
	logic                           upd_s1, upd_s2, upd_s3, upd_s4, upd_s5;
	logic signed [31:0]             err, perr_sat;
	logic signed [31:0]             err_s2, perr_s2, olderr_s2, last_err_q;
	logic signed [32:0]             derr_s3;
	logic signed [47:0]             pp_s3, pi_s3;
	logic signed [48:0]             pd_s4, ppi_s4;
	logic signed [49:0]             sum;
	logic signed [41:0]             inc_s5;
	logic signed [63:0]             thr_sum;
	logic signed [31:0]             thr_q;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > SatHi) begin
			r = 32'sh7fffffff;
		end else if (x < SatLo) begin
			r = 32'sh80000000;
		end else begin
			r = signed'(x[31:0]);
		end
		return r;
	endfunction

	assign pos_w      = PositionBits'(position);
	assign dist_w     = PositionBits'(tick_dist);
	assign ideal_base = ctl.upd ? ideal_q : pos_w;
	assign err        = sat32(64'(tick_dist) - 64'(delta_s1));
	assign perr_sat   = sat32(64'(perr_s1));
	assign sum        = 50'(ppi_s4) + 50'(pd_s4);
	assign thr_sum    = 64'(thr_q) + 64'(inc_s5);
	assign throttle   = upd_s5 ? sat32(thr_sum) : thr_q;

	// position state, written on every tick that gives a result
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			prev_pos_q <= pos_w;
			ideal_q    <= ideal_base + dist_w;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			delta_s1  <= pos_w - prev_pos_q;
			perr_s1   <= ideal_q - pos_w;
			err_s2    <= err;
			perr_s2   <= perr_sat;
			olderr_s2 <= last_err_q;
			derr_s3   <= 33'(olderr_s2) - 33'(err_s2);
			pp_s3     <= 48'(gains.p) * 48'(err_s2);
			pi_s3     <= 48'(gains.i) * 48'(perr_s2);
			pd_s4     <= 49'(gains.d) * 49'(derr_s3);
			ppi_s4    <= 49'(pp_s3) + 49'(pi_s3);
			inc_s5    <= 42'(sum >>> 8);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_s1     <= 1'b0;
			upd_s2     <= 1'b0;
			upd_s3     <= 1'b0;
			upd_s4     <= 1'b0;
			upd_s5     <= 1'b0;
			last_err_q <= '0;
			thr_q      <= '0;
		end else if (ctl.adv) begin
			upd_s1 <= ctl.upd;
			upd_s2 <= upd_s1;
			upd_s3 <= upd_s2;
			upd_s4 <= upd_s3;
			upd_s5 <= upd_s4;
			if (upd_s1) begin
				last_err_q <= err;
			end
			if (upd_s5) begin
				thr_q <= throttle;
			end
		end
	end

endmodule

@@ sv/dwcpid_merge.sv @@
// merge stage: joins both lane throttles into one output item register
// depends on dwcpid_pkg; used by dual_wheel_cruise_pid_top

module dwcpid_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               v_last,
	input  logic signed [31:0] left_throttle,
	input  logic signed [31:0] right_throttle,
	output logic               adv,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [63:0]        m_tdata  // left_throttle, right_throttle
);
	import dwcpid_pkg::*;

	logic        out_valid_q;
	logic [63:0] out_data_q;

	assign adv      = !v_last || !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk) begin
		if (v_last && adv) begin
			out_data_q <= {right_throttle, left_throttle};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (v_last && adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

@@ sv/dual_wheel_cruise_pid_top.sv @@
// two-wheel cruise speed controller: incremental pid hold of a target speed
// depends on dwcpid_pkg, dwcpid_dist, dwcpid_lane, dwcpid_merge
//
// usage:
//   s_* channel takes one item per control tick: tdata holds both wheel
//   positions, tuser flags that another behavior holds control. a ticking
//   item that finds the block disabled, or with the flag set, gives no output.
//   m_* channel gives both throttle commands for each remaining item.
//   cfg_* channel writes one register by index; cfg_ready is always high.
// timing:
//   one item per cycle while not stalled; an output item passes the five-stage
//   lane pipeline and then the output register.
//   after reset and after each register write, s_tready stays low while the
//   distance-per-tick divider pipeline settles.
// reset and stalls:
//   reset clears cruise mode, throttles, previous errors and the pipeline.
//   while m_tready is low the lanes keep moving until the output register and
//   the last stage both hold an item, then the whole pipeline and s_tready hold.

module dual_wheel_cruise_pid_top #(
	parameter int POSITION_BITS = dwcpid_pkg::POS_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [dwcpid_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                      cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [63:0]                      s_tdata,  // left_position, right_position
	input  logic                             s_tuser,  // other_in_control
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [63:0]                      m_tdata   // left_throttle, right_throttle
);
	import dwcpid_pkg::*;

	logic               en_q;
	logic signed [15:0] tgt_q;
	logic [15:0]        tick_q;
	gains_t             gains_q;
	logic               cruising_q;
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic               adv, acc, produce, dist_ok, cfg_wr;
	logic signed [31:0] tick_dist;
	logic signed [31:0] left_pos, right_pos, left_thr, right_thr;
	lane_ctl_t          ctl;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign s_tready  = adv && dist_ok;
	assign acc       = s_tvalid && s_tready;
	assign produce   = acc && en_q && !s_tuser;
	assign left_pos  = signed'(s_tdata[31:0]);
	assign right_pos = signed'(s_tdata[63:32]);

	assign ctl.adv  = adv;
	assign ctl.load = produce;
	assign ctl.upd  = produce && cruising_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q    <= 1'b1;
			tgt_q   <= '0;
			tick_q  <= 16'd100;
			gains_q <= '{p: 16'sd256, i: 16'sd128, d: 16'sd0};
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_ENABLE:       en_q      <= cfg_data[0];
				REG_TARGET_SPEED: tgt_q     <= signed'(cfg_data);
				REG_TICK_MS:      tick_q    <= cfg_data;
				REG_GAIN_P:       gains_q.p <= signed'(cfg_data);
				REG_GAIN_I:       gains_q.i <= signed'(cfg_data);
				REG_GAIN_D:       gains_q.d <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cruising_q <= 1'b0;
		end else if (acc && en_q) begin
			cruising_q <= !s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= produce;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	dwcpid_dist u_dist (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr       (cfg_wr),
		.target_speed (tgt_q),
		.tick_ms      (tick_q),
		.tick_dist    (tick_dist),
		.dist_ok      (dist_ok)
	);

	dwcpid_lane #(
		.PositionBits (POSITION_BITS)
	) u_lane_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.gains     (gains_q),
		.tick_dist (tick_dist),
		.position  (left_pos),
		.throttle  (left_thr)
	);

	dwcpid_lane #(
		.PositionBits (POSITION_BITS)
	) u_lane_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.gains     (gains_q),
		.tick_dist (tick_dist),
		.position  (right_pos),
		.throttle  (right_thr)
	);

	dwcpid_merge u_merge (
		.clk            (clk),
		.arst_n         (arst_n),
		.v_last         (v_s5),
		.left_throttle  (left_thr),
		.right_throttle (right_thr),
		.adv            (adv),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata)
	);

	a_cfg_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !s_tready)
		else $error("item taken while distance per tick settles");

	a_yield_clears_cruise: assert property (@(posedge clk) disable iff (!arst_n)
		acc && en_q && s_tuser |=> !cruising_q)
		else $error("cruise mode kept after another behavior took control");

	a_tick_enters_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		acc && en_q && !s_tuser |=> v_s1)
		else $error("controlling tick did not enter the lanes");

endmodule

@@ dv/dual_wheel_cruise_pid_top_tb.sv @@
// testbench for dual_wheel_cruise_pid_top: drives control ticks, register writes and output stalls,
// predicts both wheel throttles per tick and checks every output item in order
// depends on dwcpid_pkg and dual_wheel_cruise_pid_top
`timescale 1ns / 1ps

module dual_wheel_cruise_pid_top_tb;
	import dwcpid_pkg::*;

	localparam int     SETTLE_CYCLES = 12;
	localparam int     RANDOM_TICKS  = 460;
	localparam int     CYCLE_LIMIT   = 200000;
	localparam longint S32_MAX       = 64'sd2147483647;
	localparam longint S32_MIN       = -64'sd2147483648;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct {
		logic        occ;
		logic [31:0] lpos;
		logic [31:0] rpos;
	} tick_t;

	typedef struct {
		logic [31:0] lthr;
		logic [31:0] rthr;
	} throttle_pair_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data  = '0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [63:0]          s_tdata   = '0;  // left_position, right_position
	logic                 s_tuser   = 1'b0;  // other_in_control
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [63:0]          m_tdata;  // left_throttle, right_throttle

	dual_wheel_cruise_pid_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic               cfg_en;
	logic signed [15:0] cfg_speed;
	logic [15:0]        cfg_tick;
	logic signed [15:0] cfg_gp;
	logic signed [15:0] cfg_gi;
	logic signed [15:0] cfg_gd;
	logic               cruising;
	logic [31:0]        ideal_pos [2];
	logic [31:0]        last_pos [2];
	longint             last_err [2];
	longint             throttle_acc [2];

	throttle_pair_t throttle_q [$];
	throttle_pair_t want_pair;
	bit  steady;
	int  stall_req;
	int  stall_left;
	int  errors;
	int  ticks_sent;
	int  random_ticks;
	int  pairs_checked;
	int  writes_done;
	int  cycle_count;

	task automatic report_error(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic longint sat32(input longint x);
		if (x > S32_MAX)
			return S32_MAX;
		if (x < S32_MIN)
			return S32_MIN;
		return x;
	endfunction

	function automatic longint tick_distance();
		return (longint'(cfg_speed) * 256 * longint'(cfg_tick)) / 1000;
	endfunction

	task automatic reset_model();
		cfg_en    = 1'b1;
		cfg_speed = 16'sd0;
		cfg_tick  = 16'd100;
		cfg_gp    = 16'sd256;
		cfg_gi    = 16'sd128;
		cfg_gd    = 16'sd0;
		cruising  = 1'b0;
		for (int w = 0; w < 2; w++) begin
			ideal_pos[w]    = '0;
			last_pos[w]     = '0;
			last_err[w]     = 0;
			throttle_acc[w] = 0;
		end
	endtask

	task automatic advance_wheel(input int w, input logic [31:0] pos, input longint tick_dist);
		logic [31:0] moved;
		logic [31:0] lag;
		longint      err;
		longint      perr;
		longint      derr;
		longint      sum;
		moved = pos - last_pos[w];
		lag   = ideal_pos[w] - pos;
		err   = sat32(tick_dist - longint'($signed(moved)));
		perr  = longint'($signed(lag));
		derr  = last_err[w] - err;
		sum   = longint'(cfg_gp) * err + longint'(cfg_gi) * perr + longint'(cfg_gd) * derr;
		throttle_acc[w] = sat32(throttle_acc[w] + (sum >>> 8));
		last_err[w] = err;
		last_pos[w] = pos;
	endtask

	task automatic predict_throttles(input tick_t t);
		logic [31:0]    pos [2];
		longint         tick_dist;
		throttle_pair_t pair;
		if (!cfg_en)
			return;
		if (t.occ) begin
			cruising = 1'b0;
			return;
		end
		pos[0] = t.lpos;
		pos[1] = t.rpos;
		tick_dist = tick_distance();
		for (int w = 0; w < 2; w++) begin
			if (cruising) begin
				advance_wheel(w, pos[w], tick_dist);
			end else begin
				last_pos[w]  = pos[w];
				ideal_pos[w] = pos[w];
			end
		end
		cruising = 1'b1;
		for (int w = 0; w < 2; w++)
			ideal_pos[w] = ideal_pos[w] + tick_dist[31:0];
		pair.lthr = throttle_acc[0][31:0];
		pair.rthr = throttle_acc[1][31:0];
		throttle_q.push_back(pair);
	endtask

	task automatic send_tick(input logic occ, input logic [31:0] lpos, input logic [31:0] rpos);
		tick_t t;
		t.occ  = occ;
		t.lpos = lpos;
		t.rpos = rpos;
		if (!steady && $urandom_range(99) < 35) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {rpos, lpos};
		s_tuser  <= occ;
		do @(posedge clk); while (!s_tready);
		predict_throttles(t);
		ticks_sent++;
	endtask

	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		while (throttle_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		drain_and_settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ENABLE:       cfg_en    = value[0];
			REG_TARGET_SPEED: cfg_speed = value;
			REG_TICK_MS:      cfg_tick  = value;
			REG_GAIN_P:       cfg_gp    = value;
			REG_GAIN_I:       cfg_gi    = value;
			REG_GAIN_D:       cfg_gd    = value;
			default: ;
		endcase
		writes_done++;
	endtask

	function automatic logic [15:0] pick_signed16();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2, 3: return 16'($urandom_range(0, 1023) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic pick_setting();
		write_reg(REG_TARGET_SPEED, pick_signed16());
		case ($urandom_range(3))
			0: write_reg(REG_TICK_MS, 16'd1);
			1: write_reg(REG_TICK_MS, 16'hFFFF);
			default: write_reg(REG_TICK_MS, 16'($urandom_range(1, 500)));
		endcase
		write_reg(REG_GAIN_P, pick_signed16());
		write_reg(REG_GAIN_I, pick_signed16());
		write_reg(REG_GAIN_D, pick_signed16());
	endtask

	// mostly steady motion near the distance per tick, with lost control and jumps mixed in
	task automatic run_cruise(input int n, input bit counted);
		logic [31:0] lpos;
		logic [31:0] rpos;
		longint      stride;
		int          amp;
		int          roll;
		lpos   = $urandom;
		rpos   = $urandom;
		stride = tick_distance();
		case ($urandom_range(3))
			0: amp = 0;
			1: amp = 64;
			2: amp = 65536;
			default: amp = 1 << 20;
		endcase
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			if (roll < 6) begin
				send_tick(1'b1, $urandom, $urandom);
			end else if (roll < 10) begin
				lpos = $urandom;
				rpos = $urandom;
				send_tick(1'b0, lpos, rpos);
			end else begin
				lpos = lpos + stride[31:0] + 32'($urandom_range(0, 2 * amp) - amp);
				rpos = rpos + stride[31:0] + 32'($urandom_range(0, 2 * amp) - amp);
				send_tick(1'b0, lpos, rpos);
			end
			if (counted)
				random_ticks++;
		end
	endtask

	task automatic test_tick_sequence();
		send_tick(1'b0, 32'h0000_0000, 32'h0000_0000);
		send_tick(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_tick(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
		send_tick(1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
		send_tick(1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
		send_tick(1'b1, 32'h1234_5678, 32'h9ABC_DEF0);
		send_tick(1'b0, 32'h0064_0000, 32'h00C8_0000);
		send_tick(1'b0, 32'h0064_0005, 32'h00C7_FFF0);
	endtask

	task automatic test_register_corners();
		write_reg(REG_ENABLE, 16'd0);
		send_tick(1'b0, 32'h0001_0000, 32'h0002_0000);
		send_tick(1'b1, 32'h0003_0000, 32'h0004_0000);
		write_reg(REG_ENABLE, 16'd1);
		send_tick(1'b0, 32'h0065_0000, 32'h00C9_0000);
		write_reg(REG_TICK_MS, 16'd0);
		write_reg(REG_TARGET_SPEED, 16'h7FFF);
		send_tick(1'b0, 32'h0066_0000, 32'h00CA_0000);
		send_tick(1'b0, 32'h0066_0000, 32'h00CA_0000);
		write_reg(REG_SPARE_LO, 16'($urandom));
		write_reg(REG_SPARE_HI, 16'($urandom));
		send_tick(1'b0, 32'h0067_0000, 32'h00CB_0000);
		write_reg(REG_TARGET_SPEED, 16'h8000);
		write_reg(REG_TICK_MS, 16'hFFFF);
		write_reg(REG_GAIN_P, 16'h7FFF);
		write_reg(REG_GAIN_I, 16'h8000);
		write_reg(REG_GAIN_D, 16'h7FFF);
		send_tick(1'b0, 32'h0000_0000, 32'hFFFF_0000);
		send_tick(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
		send_tick(1'b0, 32'h8000_0001, 32'h7FFF_FFFE);
		write_reg(REG_TARGET_SPEED, 16'h7FFF);
		write_reg(REG_GAIN_P, 16'h8000);
		write_reg(REG_GAIN_I, 16'h7FFF);
		write_reg(REG_GAIN_D, 16'h8000);
		send_tick(1'b0, 32'h8000_0000, 32'h8000_0000);
		send_tick(1'b0, 32'h7FFF_FFFF, 32'h0000_0000);
		send_tick(1'b0, 32'hC000_0000, 32'h4000_0000);
	endtask

	task automatic test_output_stall();
		write_reg(REG_ENABLE, 16'd1);
		write_reg(REG_TARGET_SPEED, 16'd512);
		write_reg(REG_TICK_MS, 16'd100);
		write_reg(REG_GAIN_P, 16'd256);
		write_reg(REG_GAIN_I, 16'd128);
		write_reg(REG_GAIN_D, 16'd64);
		steady    = 1'b1;
		stall_req = 150;
		run_cruise(40, 1'b0);
		steady = 1'b0;
	endtask

	task automatic test_random_cruise();
		int phase;
		phase = 0;
		while (random_ticks < RANDOM_TICKS) begin
			steady = (phase == 1);
			pick_setting();
			if (phase == 4) begin
				write_reg(REG_ENABLE, 16'd0);
				run_cruise(8, 1'b0);
				write_reg(REG_ENABLE, 16'd1);
			end
			run_cruise($urandom_range(25, 45), 1'b1);
			if (phase == 2)
				drain_and_settle();
			run_cruise($urandom_range(15, 30), 1'b1);
			phase++;
		end
		steady = 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (throttle_q.size() == 0) begin
					report_error($sformatf("unexpected item %h", m_tdata));
				end else begin
					want_pair = throttle_q.pop_front();
					pairs_checked++;
					if (m_tdata[31:0] !== want_pair.lthr)
						report_error($sformatf("left throttle got %h want %h",
							m_tdata[31:0], want_pair.lthr));
					if (m_tdata[63:32] !== want_pair.rthr)
						report_error($sformatf("right throttle got %h want %h",
							m_tdata[63:32], want_pair.rthr));
				end
			end
		end
	end

	// receiver side: random idling and counted long holds
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_req > 0) begin
				stall_left = stall_req;
				stall_req  = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(99) >= 35);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("dual_wheel_cruise_pid_top_tb: done, errors");
		$finish;
	end

	initial begin
		reset_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_tick_sequence();
		test_register_corners();
		test_output_stall();
		test_random_cruise();
		s_tvalid <= 1'b0;
		while (throttle_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("ran %0d ticks over %0d register writes, %0d throttle pairs compared",
			ticks_sent, writes_done, pairs_checked);
		$display("covered lost control, disabled ticks, position wrap, saturation, output stall");
		if (errors == 0)
			$display("dual_wheel_cruise_pid_top_tb: done, clean");
		else
			$display("dual_wheel_cruise_pid_top_tb: done, errors");
		$finish;
	end

endmodule

@@ files.f @@
sv/dwcpid_pkg.sv
sv/dwcpid_dist.sv
sv/dwcpid_lane.sv
sv/dwcpid_merge.sv
sv/dual_wheel_cruise_pid_top.sv
dv/dual_wheel_cruise_pid_top_tb.sv
